[rtl/core/dropout_mt19937_mask_macros.svh]
// assertion macros used by the checker of the dropout block
`ifndef DROPOUT_MT19937_MASK_MACROS_SVH
`define DROPOUT_MT19937_MASK_MACROS_SVH

// same-cycle implication
`define DMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmt check failed");

// next-cycle implication
`define DMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmt check failed");

`endif

[rtl/core/dmt_pkg.sv]
package dmt_pkg;

	localparam int unsigned MtN    = 624;
	localparam int unsigned MtM    = 397;
	localparam int unsigned IdxW   = 10;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = 2;

	localparam logic [31:0] MtInitMul  = 32'd1812433253;
	localparam logic [31:0] MtMatrix   = 32'h9908B0DF;
	localparam logic [31:0] TemperB    = 32'h9D2C5680;
	localparam logic [31:0] TemperC    = 32'hEFC60000;
	localparam logic [31:0] FloatQnan  = 32'h7FC00000;
	localparam logic [31:0] FloatZero  = 32'h00000000;
	localparam logic [31:0] SeedRst    = 32'h00000000;
	localparam logic [31:0] ThrRst     = 32'h80000000;
	localparam logic [31:0] ScaleRst   = 32'h40000000;

	typedef enum logic [2:0] {
		REG_TRAINING  = 3'd0,
		REG_SEED      = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_SCALE     = 3'd3
	} dmt_reg_t;

	typedef struct packed {
		logic [31:0] value;
		logic        keep;
		logic        mul;
	} dmt_item_t;

	typedef struct packed {
		logic take;
		logic reseed;
	} dmt_gen_ctl_t;

	typedef struct packed {
		logic        vld;
		logic [31:0] word;
	} dmt_gen_sts_t;

	function automatic logic [31:0] dmt_temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] dmt_twist(input logic [31:0] cur, input logic [31:0] nxt,
		input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = {cur[31], nxt[30:0]};
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MtMatrix;
		end
		return v;
	endfunction

endpackage

[rtl/core/dropout_mt19937_mask.sv]
// Dropout with a Mersenne Twister (MT19937) mask, one single-precision element per request.
// Input stream: s_axis_tdata carries the element bits, s_axis_tlast marks the last element
// of a tensor. Output stream: m_axis_tdata carries the result, m_axis_tuser the keep bit.
// Registers are written on the cfg channel (index 0 training, 1 seed, 2 threshold, 3 scale);
// cfg_ready is always high and a seed write restarts the generator.
// Throughput is one element per cycle when not stalled; each drawing element consumes
// one word that the generator builds incrementally from a two-read, one-write state memory
// of 624 words. Accepted elements are registered in the queue, then in each pipeline stage.
// After reset, after a seed write and after an element marked last, the generator runs a
// seeding pass through the state memory, one word a cycle; while it runs elements that
// need a draw wait, pass-through elements still flow.
// A four-entry queue separates the input side from the multiplier pipeline, so the input
// keeps accepting while a result waits; when the receiver stalls, the pipeline and then the
// queue fill and s_axis_tready falls.
module dropout_mt19937_mask (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // data_value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_value
	output logic        m_axis_tuser,   // keep_flag
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import dmt_pkg::*;

	dmt_gen_ctl_t gen_ctl;
	dmt_gen_sts_t gen_sts;
	dmt_item_t    push_item;
	dmt_item_t    head_item;
	logic [31:0]  seed;
	logic [31:0]  scale;
	logic         q_full;
	logic         q_push;
	logic         q_pop;
	logic         head_vld;

	dmt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sts           (gen_sts),
		.ctl           (gen_ctl),
		.seed          (seed),
		.scale         (scale),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	dmt_twister u_twister (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gen_ctl),
		.seed   (seed),
		.sts    (gen_sts)
	);

	dmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_vld  (head_vld),
		.head_item (head_item)
	);

	dmt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_vld         (head_vld),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.scale         (scale),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

[rtl/core/dmt_twister.sv]
module dmt_twister (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmt_pkg::dmt_gen_ctl_t ctl,
	input  logic [31:0]          seed,
	output dmt_pkg::dmt_gen_sts_t sts
);
	import dmt_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SEED  = 4'b0010,
		ST_PRIME = 4'b0100,
		ST_RUN   = 4'b1000
	} gen_state_t;

	gen_state_t state_q;
	logic [IdxW-1:0] k_q;
	logic [IdxW-1:0] i_q;
	logic [31:0] p_q;
	logic [31:0] cur_q;
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [31:0] word_q;
	logic        word_vld_q;
	logic [31:0] mem [MtN];

	logic            gen;
	logic            wr_en;
	logic            rd_en;
	logic [IdxW-1:0] wr_addr;
	logic [31:0]     wr_data;
	logic [31:0]     seed_next;
	logic [31:0]     twist_word;
	logic [IdxW-1:0] nx;
	logic [IdxW:0]   a_sum;
	logic [IdxW:0]   b_sum;
	logic [IdxW-1:0] rd_a_addr;
	logic [IdxW-1:0] rd_b_addr;

	assign seed_next  = MtInitMul * (p_q ^ (p_q >> 30)) + {{(32-IdxW){1'b0}}, k_q};
	assign twist_word = dmt_twist(cur_q, rd_a_q, rd_b_q);
	assign gen        = (state_q == ST_RUN) && (!word_vld_q || ctl.take);
	assign rd_en      = (state_q == ST_PRIME) || gen;

	always_comb begin
		if (state_q == ST_PRIME || i_q == IdxW'(MtN - 1)) begin
			nx = '0;
		end else begin
			nx = i_q + 1'b1;
		end
		a_sum = {1'b0, nx} + (IdxW+1)'(1);
		b_sum = {1'b0, nx} + (IdxW+1)'(MtM);
		rd_a_addr = (a_sum >= (IdxW+1)'(MtN)) ? IdxW'(a_sum - (IdxW+1)'(MtN)) : a_sum[IdxW-1:0];
		rd_b_addr = (b_sum >= (IdxW+1)'(MtN)) ? IdxW'(b_sum - (IdxW+1)'(MtN)) : b_sum[IdxW-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = twist_word;
		unique case (state_q)
			ST_LOAD: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = seed;
			end
			ST_SEED: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = seed_next;
			end
			ST_RUN: begin
				wr_en = gen;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			k_q        <= '0;
			i_q        <= '0;
			word_vld_q <= 1'b0;
		end else if (ctl.reseed) begin
			state_q    <= ST_LOAD;
			word_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					k_q     <= IdxW'(1);
					state_q <= ST_SEED;
				end
				ST_SEED: begin
					k_q <= k_q + 1'b1;
					if (k_q == IdxW'(MtN - 1)) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					i_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (gen) begin
						i_q        <= nx;
						word_vld_q <= 1'b1;
					end else if (ctl.take) begin
						word_vld_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			p_q   <= seed;
			cur_q <= seed;
		end else if (state_q == ST_SEED) begin
			p_q <= seed_next;
		end else if (gen) begin
			cur_q  <= rd_a_q;
			word_q <= dmt_temper(twist_word);
		end
	end

	assign sts.vld  = word_vld_q;
	assign sts.word = word_q;

endmodule

[rtl/core/dmt_front.sv]
module dmt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,
	input  logic                  s_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  dmt_pkg::dmt_gen_sts_t sts,
	output dmt_pkg::dmt_gen_ctl_t ctl,
	output logic [31:0]           seed,
	output logic [31:0]           scale,
	input  logic                  q_full,
	output logic                  q_push,
	output dmt_pkg::dmt_item_t    q_item
);
	import dmt_pkg::*;

	logic        training_q;
	logic [31:0] seed_q;
	logic [31:0] thr_q;
	logic [31:0] scale_q;
	logic        draw;
	logic        keep;
	logic        acc;
	logic        seed_wr;

	assign cfg_ready     = 1'b1;
	assign draw          = training_q && (thr_q != 32'd0);
	assign s_axis_tready = !q_full && (!draw || sts.vld);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign keep          = !draw || (sts.word >= thr_q);
	assign seed_wr       = cfg_valid && (cfg_index == REG_SEED);

	assign q_push       = acc;
	assign q_item.value = keep ? s_axis_tdata : FloatZero;
	assign q_item.keep  = keep;
	assign q_item.mul   = draw && keep;

	assign ctl.take   = acc && draw;
	assign ctl.reseed = (acc && s_axis_tlast) || seed_wr;

	assign seed  = seed_q;
	assign scale = scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			training_q <= 1'b0;
			seed_q     <= SeedRst;
			thr_q      <= ThrRst;
			scale_q    <= ScaleRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TRAINING:  training_q <= cfg_data[0];
				REG_SEED:      seed_q     <= cfg_data;
				REG_THRESHOLD: thr_q      <= cfg_data;
				REG_SCALE:     scale_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/dmt_queue.sv]
module dmt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dmt_pkg::dmt_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_vld,
	output dmt_pkg::dmt_item_t head_item
);
	import dmt_pkg::*;

	dmt_item_t        ent_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QPtrW:0]   cnt_q;
	logic             do_pop;

	assign full      = (cnt_q == (QPtrW+1)'(QDepth));
	assign head_vld  = (cnt_q != '0);
	assign head_item = ent_q[rd_q];
	assign do_pop    = pop && head_vld;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/dmt_back.sv]
module dmt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_vld,
	input  dmt_pkg::dmt_item_t q_item,
	output logic               q_pop,
	input  logic [31:0]        scale,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [31:0]        m_axis_tdata,
	output logic               m_axis_tuser
);
	import dmt_pkg::*;

	function automatic logic [5:0] lzc48(input logic [47:0] x);
		logic [5:0] n;
		logic       found;
		n     = 6'd0;
		found = 1'b0;
		for (int j = 47; j >= 0; j--) begin
			if (!found) begin
				if (x[j]) begin
					found = 1'b1;
				end else begin
					n = n + 6'd1;
				end
			end
		end
		return n;
	endfunction

	logic en1, en2, en3;

	// stage 1: specials and significand product
	logic [7:0]  ea, eb;
	logic [22:0] ma, mb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic        spec;
	logic [31:0] spec_val;
	logic [23:0] siga, sigb;
	logic [8:0]  esum;

	logic        v_s1, keep_s1, spec_s1, sign_s1;
	logic [31:0] val_s1;
	logic [8:0]  esum_s1;
	logic [47:0] prod_s1;

	logic        v_s2, keep_s2, spec_s2, sign_s2;
	logic [31:0] val_s2;
	logic signed [10:0] e_s2;
	logic [47:0] pn_s2;

	logic        v_s3, keep_s3;
	logic [31:0] data_s3;

	logic [5:0]  lz;
	logic signed [10:0] e_w;
	logic        ovf, normal;
	logic signed [10:0] sh_w;
	logic [5:0]  sh;
	logic [98:0] ext;
	logic [23:0] q;
	logic        guard, sticky;
	logic [30:0] base, enc, rnd;
	logic [31:0] fin;

	assign en3   = !v_s3 || m_axis_tready;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign q_pop = en1;

	assign ea = q_item.value[30:23];
	assign ma = q_item.value[22:0];
	assign eb = scale[30:23];
	assign mb = scale[22:0];
	assign a_nan  = (ea == 8'hFF) && (ma != '0);
	assign b_nan  = (eb == 8'hFF) && (mb != '0);
	assign a_inf  = (ea == 8'hFF) && (ma == '0);
	assign b_inf  = (eb == 8'hFF) && (mb == '0);
	assign a_zero = (ea == 8'h00) && (ma == '0);
	assign b_zero = (eb == 8'h00) && (mb == '0);
	assign sgn    = q_item.value[31] ^ scale[31];
	assign siga   = {ea != 8'h00, ma};
	assign sigb   = {eb != 8'h00, mb};
	assign esum   = {1'b0, (ea == 8'h00) ? 8'd1 : ea} + {1'b0, (eb == 8'h00) ? 8'd1 : eb};

	always_comb begin
		spec     = 1'b1;
		spec_val = q_item.value;
		if (!q_item.mul) begin
			spec_val = q_item.value;
		end else if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
			spec_val = FloatQnan;
		end else if (a_inf || b_inf) begin
			spec_val = {sgn, 8'hFF, 23'd0};
		end else if (a_zero || b_zero) begin
			spec_val = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
	end

	// stage 2: normalise
	assign lz  = lzc48(prod_s1);
	assign e_w = $signed({2'b00, esum_s1}) - 11'sd126 - $signed({5'b00000, lz});

	// stage 3: align, round, pack
	assign ovf    = (e_s2 >= 11'sd255);
	assign normal = (e_s2 >= 11'sd1);
	assign sh_w   = 11'sd25 - e_s2;
	always_comb begin
		if (normal) begin
			sh = 6'd24;
		end else if (e_s2 <= -11'sd24) begin
			sh = 6'd49;
		end else begin
			sh = sh_w[5:0];
		end
	end
	assign ext    = {pn_s2, 51'd0} >> sh;
	assign q      = ext[74:51];
	assign guard  = ext[50];
	assign sticky = |ext[49:0];
	assign base   = normal ? {8'(e_s2 - 11'sd1), 23'd0} : 31'd0;
	assign enc    = base + {7'd0, q};
	assign rnd    = enc + {30'd0, guard & (sticky | q[0])};
	assign fin    = ovf ? {sign_s2, 8'hFF, 23'd0} : {sign_s2, rnd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= q_vld;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			keep_s1 <= q_item.keep;
			spec_s1 <= spec;
			val_s1  <= spec_val;
			sign_s1 <= sgn;
			esum_s1 <= esum;
			prod_s1 <= siga * sigb;
		end
		if (en2) begin
			keep_s2 <= keep_s1;
			spec_s2 <= spec_s1;
			val_s2  <= val_s1;
			sign_s2 <= sign_s1;
			e_s2    <= e_w;
			pn_s2   <= prod_s1 << lz;
		end
		if (en3) begin
			keep_s3 <= keep_s2;
			data_s3 <= spec_s2 ? val_s2 : fin;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = data_s3;
	assign m_axis_tuser  = keep_s3;

endmodule

[rtl/core/dmt_checker.sv]
`include "dropout_mt19937_mask_macros.svh"

module dmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// stalled result stays offered
	`DMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// stalled result keeps its payload
	`DMT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// dropped elements come out as positive zero
	`DMT_ASSERT_NOW(a_drop_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)

	// nothing offered straight after reset
	`DMT_ASSERT_NOW(a_reset_quiet, $past(!arst_n), !m_axis_tvalid)

endmodule

bind dropout_mt19937_mask dmt_checker u_dmt_checker (.*);
